### src/lkv_pkg.sv
// ============================================================================
// lkv_pkg: shared types and constants of the LRU key-value table
// Field widths of the stream payloads, command codes and the per-cell
// operation broadcast together with the cell-to-cell chain signals.
// ============================================================================
package lkv_pkg;

    // Stream field widths
    localparam int KEY_FIELD_W   = 32;
    localparam int VALUE_FIELD_W = 32;
    localparam int EVICT_FIELD_W = 3;
    localparam int COUNT_FIELD_W = 7;
    localparam int S_TDATA_W     = KEY_FIELD_W + VALUE_FIELD_W;
    localparam int M_FIELDS_W    = 1 + VALUE_FIELD_W + 1 + EVICT_FIELD_W + COUNT_FIELD_W;
    localparam int M_TDATA_W     = ((M_FIELDS_W + 7) / 8) * 8;

    // Command codes carried in s_tuser
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // What every cell does with the current item
    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_PROMOTE = 2'd1,
        OP_INSERT  = 2'd2,
        OP_EVICT   = 2'd3
    } lkv_kind_t;

    // Broadcast from the controller to all cells
    typedef struct packed {
        logic      commit;      // apply the update at this edge
        lkv_kind_t kind;
        logic      write_data;  // a put hit overwrites the value
    } lkv_op_t;

    // Passed from one cell to the next: first-match and first-free claims
    typedef struct packed {
        logic match_seen;
        logic free_seen;
    } lkv_chain_t;

endpackage

### src/lkv_cell.sv
// ============================================================================
// lkv_cell: one entry of the LRU key-value table
// Holds key, value, valid bit and recency rank; compares the request key,
// claims first match or first free slot along the chain, updates its rank.
// ============================================================================
module lkv_cell #(
    parameter int KEY_W   = 32,
    parameter int VALUE_W = 32,
    parameter int RANK_W  = 4,
    parameter int KEEP    = 15
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lkv_pkg::lkv_op_t    op,
    input  logic [KEY_W-1:0]    req_key,
    input  logic [VALUE_W-1:0]  req_value,
    input  logic [RANK_W-1:0]   hit_rank,
    input  lkv_pkg::lkv_chain_t chain_in,
    output lkv_pkg::lkv_chain_t chain_out,
    output logic                match,
    output logic                valid,
    output logic [VALUE_W-1:0]  data,
    output logic [RANK_W-1:0]   rank
);
    import lkv_pkg::*;

    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] data_reg;
    logic               valid_reg, valid_next;
    logic [RANK_W-1:0]  rank_reg, rank_next;
    logic               hit_here;
    logic               free_here;

    // Compare and claim along the chain
    assign hit_here  = valid_reg && (key_reg == req_key);
    assign match     = hit_here && !chain_in.match_seen;
    assign free_here = !valid_reg && !chain_in.free_seen;

    assign chain_out.match_seen = chain_in.match_seen | hit_here;
    assign chain_out.free_seen  = chain_in.free_seen | !valid_reg;

    assign valid = valid_reg;
    assign data  = data_reg;
    assign rank  = rank_reg;

    // Next valid bit and rank for the broadcast operation
    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        unique case (op.kind)
            OP_PROMOTE: begin
                if (match) begin
                    rank_next = '0;
                end else if (valid_reg && (rank_reg < hit_rank)) begin
                    rank_next = rank_reg + RANK_W'(1);
                end
            end
            OP_INSERT: begin
                if (free_here) begin
                    valid_next = 1'b1;
                    rank_next  = '0;
                end else if (valid_reg) begin
                    rank_next = rank_reg + RANK_W'(1);
                end
            end
            OP_EVICT: begin
                if (valid_reg && (rank_reg >= RANK_W'(KEEP))) begin
                    valid_next = 1'b0;
                    rank_next  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else if (op.commit) begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    // Payload: written on insert, value overwritten on put hit
    always_ff @(posedge aclk) begin
        if (op.commit && (op.kind == OP_INSERT) && free_here) begin
            key_reg  <= req_key;
            data_reg <= req_value;
        end else if (op.commit && (op.kind == OP_PROMOTE) && op.write_data && match) begin
            data_reg <= req_value;
        end
    end

endmodule

### src/lru_key_value_table.sv
// ============================================================================
// lru_key_value_table: fixed-capacity key-value table in recency order
// A row of entry cells compares the key in parallel, claims the first match
// or free slot along a chain and updates ranks; a full table drops the new
// item and evicts the least recent entries.
// ============================================================================
//
//  channel   dir   handshake            payload
//  s_        in    s_tvalid/s_tready    tuser: cmd; tdata: key, put_value
//  m_        out   m_tvalid/m_tready    tdata: hit, read_value, stored,
//                                              evicted_count, entry_count
//
//  An item is handled in ST_IDLE, which registers the request, then in ST_EXEC,
//  in which all cells compare and update together and the result is written
//  to the output register. No new item is accepted until it leaves ST_EXEC.
//  A stalled output holds the item in the update cycle and blocks input
//  until the output register is free; one item still enters while a result waits.
//  aresetn (synchronous) clears all valid bits, ranks and the entry count.
//
module lru_key_value_table #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata, low to high: key[31:0], put_value[63:32]
    input  logic [lkv_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: cmd
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata, low to high: hit[0], read_value[32:1], stored[33],
    // evicted_count[36:34], entry_count[43:37], zero fill above
    output logic [lkv_pkg::M_TDATA_W-1:0]  m_tdata
);
    import lkv_pkg::*;

    localparam int KEY_W   = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int VALUE_W = (VALUE_BITS < VALUE_FIELD_W) ? VALUE_BITS : VALUE_FIELD_W;
    localparam int RANK_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int EVICT_N = ((CAPACITY / 10) < 1) ? 1 : (CAPACITY / 10);
    localparam int KEEP    = CAPACITY - EVICT_N;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic                 cmd_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    lkv_op_t              op;
    lkv_chain_t           chain [0:CAPACITY];
    logic [CAPACITY-1:0]  match_vec;
    logic [CAPACITY-1:0]  valid_vec;
    logic [VALUE_W-1:0]   cell_data [CAPACITY];
    logic [RANK_W-1:0]    cell_rank [CAPACITY];
    logic [VALUE_W-1:0]   hit_data;
    logic [RANK_W-1:0]    hit_rank;
    logic                 any_hit;
    logic                 any_free;
    logic                 out_free;
    logic                 r_stored;
    logic [VALUE_W-1:0]   r_read;
    logic [EVICT_FIELD_W-1:0] r_evicted;

    // Handshake
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Entry row
    assign chain[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        lkv_cell #(
            .KEY_W   (KEY_W),
            .VALUE_W (VALUE_W),
            .RANK_W  (RANK_W),
            .KEEP    (KEEP)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (op),
            .req_key   (key_reg),
            .req_value (value_reg),
            .hit_rank  (hit_rank),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .match     (match_vec[g]),
            .valid     (valid_vec[g]),
            .data      (cell_data[g]),
            .rank      (cell_rank[g])
        );
    end

    assign any_hit  = chain[CAPACITY].match_seen;
    assign any_free = chain[CAPACITY].free_seen;

    // Gather value and rank of the matching entry
    always_comb begin
        hit_data = '0;
        hit_rank = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (match_vec[i]) begin
                hit_data = hit_data | cell_data[i];
                hit_rank = hit_rank | cell_rank[i];
            end
        end
    end

    // Decide the operation for all cells
    always_comb begin
        op.commit     = (state_reg == ST_EXEC) && out_free;
        op.write_data = (cmd_reg == CMD_PUT);
        priority if (any_hit) begin
            op.kind = OP_PROMOTE;
        end else if ((cmd_reg == CMD_PUT) && any_free) begin
            op.kind = OP_INSERT;
        end else if (cmd_reg == CMD_PUT) begin
            op.kind = OP_EVICT;
        end else begin
            op.kind = OP_NONE;
        end
    end

    // Result fields and next count
    always_comb begin
        count_next = count_reg;
        r_evicted  = '0;
        r_stored   = (cmd_reg == CMD_PUT) && (any_hit || any_free);
        r_read     = ((cmd_reg == CMD_GET) && any_hit) ? hit_data : '0;
        unique case (op.kind)
            OP_INSERT: count_next = count_reg + CNT_W'(1);
            OP_EVICT: begin
                count_next = count_reg - CNT_W'(EVICT_N);
                r_evicted  = EVICT_FIELD_W'(EVICT_N);
            end
            default: begin
            end
        endcase
        m_data_next = M_TDATA_W'({COUNT_FIELD_W'(count_next), r_evicted, r_stored,
                                  VALUE_FIELD_W'(r_read), any_hit});
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (op.commit) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture request and result
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg   <= s_tuser;
            key_reg   <= s_tdata[KEY_W-1:0];
            value_reg <= s_tdata[KEY_FIELD_W +: VALUE_W];
        end
        if (op.commit) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("entry count differs from valid entries");

    a_one_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("more than one cell claims the match");

    a_evict_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (op.commit && (op.kind == OP_EVICT)) |=> (count_reg == CNT_W'(KEEP)))
        else $error("eviction left wrong entry count");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EXEC) && (op.kind == OP_EVICT)) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("eviction on a table that is not full");
`endif

endmodule
